// ===== design/dsl_pkg.sv =====
// Shared types and constants for the scatter list builder.
`default_nettype none

package dsl_pkg;

  // Fixed field widths.
  localparam int ADDR_W   = 64;
  localparam int DEV_W    = 32;
  localparam int LEN_W    = 13;
  localparam int SEC_W    = 24;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int CFG_W    = 32;
  localparam int REG_IDX_W = 2;

  // Limits of the list and page geometry.
  localparam logic [LEN_W-1:0] PAGE_BYTES    = 13'd4096;
  localparam logic [CNT_W-1:0] MAX_ENTRIES   = 11'd1024;
  localparam logic [SEC_W-1:0] MIN_SECTION   = 24'd128;

  // Register reset values.
  localparam logic [SEC_W-1:0] SECTION_RESET  = 24'd4096;
  localparam logic [DEV_W-1:0] LOCAL_RESET    = 32'd0;
  localparam logic             TO_HOST_RESET  = 1'b1;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd1024;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_SECTION_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOCAL_ADDRESS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TO_HOST        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_CAPACITY = 2'd3;

  // One input beat: a data page.
  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic [LEN_W-1:0]  page_bytes;
    logic              last_page;
  } in_item_t;

  // One result beat: a descriptor or an error marker.
  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] bus_address;
    logic [DEV_W-1:0]  device_address;
    logic [LEN_W-1:0]  byte_count;
    logic              direction_in;
    logic              term_interrupt;
    logic [IDX_W-1:0]  next_index;
    logic              end_of_chain;
    logic              overflow_error;
    logic              last;
  } out_item_t;

  // Clamped configuration handed to the sequencer.
  typedef struct packed {
    logic [SEC_W-1:0] section;
    logic [DEV_W-1:0] local_address;
    logic             to_host;
    logic [CNT_W-1:0] capacity;
  } cfg_t;

  // Result of one pass through the piece unit.
  typedef struct packed {
    logic             closes_section;
    logic [LEN_W-1:0] piece;
    logic [LEN_W-1:0] len_left;
    logic [SEC_W-1:0] rem_next;
  } cut_t;

endpackage

`default_nettype wire

// ===== design/dsl_piece_alu.sv =====
// Shared compare and subtract unit that cuts one piece off a page.
`default_nettype none

module dsl_piece_alu (
  input  wire logic [dsl_pkg::LEN_W-1:0] len,
  input  wire logic [dsl_pkg::SEC_W-1:0] rem,
  input  wire logic [dsl_pkg::SEC_W-1:0] section,
  output dsl_pkg::cut_t                  cut
);

  logic [dsl_pkg::SEC_W:0] diff;
  logic                    ge;

  // One subtractor serves both the compare and the new remainders.
  assign diff = {{(dsl_pkg::SEC_W - dsl_pkg::LEN_W + 1){1'b0}}, len} - {1'b0, rem};
  assign ge   = ~diff[dsl_pkg::SEC_W];

  // When the page reaches the section end, rem is at most the page length.
  always_comb begin
    cut.closes_section = ge;
    if (ge) begin
      cut.piece    = rem[dsl_pkg::LEN_W-1:0];
      cut.len_left = diff[dsl_pkg::LEN_W-1:0];
      cut.rem_next = section;
    end else begin
      cut.piece    = len;
      cut.len_left = '0;
      cut.rem_next = ~diff[dsl_pkg::SEC_W-1:0] + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/dsl_ctrl.sv =====
// Sequencer that walks one page through the piece unit and fills the result register.
`default_nettype none

module dsl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dsl_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dsl_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dsl_pkg::out_item_t     out_data
);

  typedef enum logic [0:0] {ST_IDLE, ST_CUT} state_t;

  state_t                      state_r, state_nxt;
  logic [dsl_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [dsl_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [dsl_pkg::LEN_W-1:0]   off_r, off_nxt;
  logic                        lastp_r, lastp_nxt;
  logic [dsl_pkg::SEC_W-1:0]   rem_r, rem_nxt;
  logic [dsl_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        aborted_r, aborted_nxt;
  logic                        out_valid_r, out_valid_nxt;
  dsl_pkg::out_item_t          out_data_r, out_data_nxt;

  dsl_pkg::cut_t               cut;
  logic [dsl_pkg::LEN_W-1:0]   in_len;
  logic [dsl_pkg::CNT_W-1:0]   cnt_inc;
  logic                        slot_free;
  logic                        chain_end;

  dsl_piece_alu u_alu (
    .len     (len_r),
    .rem     (rem_r),
    .section (cfg.section),
    .cut     (cut)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Oversized pages are cut down to the page size.
  assign in_len = (in_data.page_bytes > dsl_pkg::PAGE_BYTES) ? dsl_pkg::PAGE_BYTES
                                                             : in_data.page_bytes;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign cnt_inc   = cnt_r + 1'b1;
  assign chain_end = lastp_r & (cut.len_left == '0);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    off_nxt       = off_r;
    lastp_nxt     = lastp_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    aborted_nxt   = aborted_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        // Take a page; aborted transfers and empty pages finish at once.
        if (in_valid) begin
          addr_nxt  = in_data.page_address;
          len_nxt   = in_len;
          off_nxt   = '0;
          lastp_nxt = in_data.last_page;
          if (aborted_r) begin
            if (in_data.last_page) begin
              cnt_nxt     = '0;
              aborted_nxt = 1'b0;
              rem_nxt     = cfg.section;
            end
          end else begin
            if (cnt_r == '0) begin
              rem_nxt = cfg.section;
            end
            if (in_len == '0) begin
              if (in_data.last_page) begin
                cnt_nxt = '0;
                rem_nxt = cfg.section;
              end
            end else begin
              state_nxt = ST_CUT;
            end
          end
        end
      end

      ST_CUT: begin
        // One descriptor or error marker per cycle while the result register has room.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (cnt_r >= cfg.capacity) begin
            out_data_nxt                = '0;
            out_data_nxt.overflow_error = 1'b1;
            out_data_nxt.last           = 1'b1;
            state_nxt                   = ST_IDLE;
            if (lastp_r) begin
              cnt_nxt     = '0;
              aborted_nxt = 1'b0;
              rem_nxt     = cfg.section;
            end else begin
              aborted_nxt = 1'b1;
            end
          end else begin
            out_data_nxt.entry_index    = cnt_r[dsl_pkg::IDX_W-1:0];
            out_data_nxt.bus_address    = addr_r +
              {{(dsl_pkg::ADDR_W - dsl_pkg::LEN_W){1'b0}}, off_r};
            out_data_nxt.device_address = cfg.local_address;
            out_data_nxt.byte_count     = cut.piece;
            out_data_nxt.direction_in   = cfg.to_host;
            out_data_nxt.term_interrupt = cut.closes_section | chain_end;
            out_data_nxt.next_index     = (chain_end || cnt_inc >= cfg.capacity)
                                          ? '0 : cnt_inc[dsl_pkg::IDX_W-1:0];
            out_data_nxt.end_of_chain   = chain_end;
            out_data_nxt.overflow_error = 1'b0;
            out_data_nxt.last           = (cut.len_left == '0);
            len_nxt = cut.len_left;
            off_nxt = off_r + cut.piece;
            rem_nxt = cut.rem_next;
            cnt_nxt = cnt_inc;
            if (cut.len_left == '0) begin
              state_nxt = ST_IDLE;
              if (lastp_r) begin
                cnt_nxt = '0;
                rem_nxt = cfg.section;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rem_r       <= dsl_pkg::SECTION_RESET;
      cnt_r       <= '0;
      aborted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
      aborted_r   <= aborted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    off_r      <= off_nxt;
    lastp_r    <= lastp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== design/dma_scatter_list_builder.sv =====
// Top level of the scatter list builder: configuration registers and the sequencer.
//
//   Port group   Direction  Carries
//   in_*         input      one data page per beat (valid / stall)
//   out_*        output     one descriptor or error marker per beat (valid / stall)
//   cfg_*        input      register writes (enable, index, data)
//
// A page is taken while the sequencer is idle; each beat it yields (descriptor or error
// marker) is then cut by the shared compare and subtract unit, and no new page is taken
// before its last beat. An empty or dropped page finishes as it is taken. A held output
// stall freezes the cutting loop. Reset is synchronous and loads the register defaults.
`default_nettype none

module dma_scatter_list_builder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dsl_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsl_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire dsl_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output dsl_pkg::out_item_t                    out_data
);

  logic [dsl_pkg::SEC_W-1:0] section_r;
  logic [dsl_pkg::DEV_W-1:0] local_r;
  logic                      to_host_r;
  logic [dsl_pkg::CNT_W-1:0] capacity_r;
  dsl_pkg::cfg_t             cfg;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r  <= dsl_pkg::SECTION_RESET;
      local_r    <= dsl_pkg::LOCAL_RESET;
      to_host_r  <= dsl_pkg::TO_HOST_RESET;
      capacity_r <= dsl_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dsl_pkg::REG_SECTION_LENGTH: section_r  <= cfg_data[dsl_pkg::SEC_W-1:0];
        dsl_pkg::REG_LOCAL_ADDRESS:  local_r    <= cfg_data[dsl_pkg::DEV_W-1:0];
        dsl_pkg::REG_TO_HOST:        to_host_r  <= cfg_data[0];
        dsl_pkg::REG_ENTRY_CAPACITY: capacity_r <= cfg_data[dsl_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the section length and the slot count to their legal ranges.
  always_comb begin
    cfg.section       = (section_r < dsl_pkg::MIN_SECTION) ? dsl_pkg::MIN_SECTION
                                                           : section_r;
    cfg.local_address = local_r;
    cfg.to_host       = to_host_r;
    if (capacity_r == '0) begin
      cfg.capacity = {{(dsl_pkg::CNT_W-1){1'b0}}, 1'b1};
    end else if (capacity_r > dsl_pkg::MAX_ENTRIES) begin
      cfg.capacity = dsl_pkg::MAX_ENTRIES;
    end else begin
      cfg.capacity = capacity_r;
    end
  end

  dsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the scatter list builder: predicted descriptors vs. output beats.
`timescale 1ns / 100ps

module tb_top;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [dsl_pkg::REG_IDX_W-1:0] cfg_index;
  logic [dsl_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  dsl_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  dsl_pkg::out_item_t            out_data;

  // Shared controls for the idling processes.
  bit idle_en      = 1'b1;
  bit hold_request = 1'b0;
  int mismatches   = 0;

  // Register copies and list state of the predictor.
  logic [dsl_pkg::SEC_W-1:0] reg_section;
  logic [dsl_pkg::DEV_W-1:0] reg_local;
  logic                      reg_to_host;
  logic [dsl_pkg::CNT_W-1:0] reg_capacity;
  logic [dsl_pkg::SEC_W-1:0] sec_left;
  logic [dsl_pkg::CNT_W-1:0] next_slot;
  bit                        dropping;

  // Descriptors still owed by the block, oldest first.
  dsl_pkg::out_item_t pending_descs[$];
  dsl_pkg::out_item_t want_desc;

  dma_scatter_list_builder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [dsl_pkg::SEC_W-1:0] eff_section();
    return (reg_section < dsl_pkg::MIN_SECTION) ? dsl_pkg::MIN_SECTION : reg_section;
  endfunction

  function automatic logic [dsl_pkg::CNT_W-1:0] eff_capacity();
    if (reg_capacity == '0) return 11'd1;
    if (reg_capacity > dsl_pkg::MAX_ENTRIES) return dsl_pkg::MAX_ENTRIES;
    return reg_capacity;
  endfunction

  function automatic void rearm_list();
    next_slot = '0;
    dropping  = 1'b0;
    sec_left  = eff_section();
  endfunction

  // Cut one accepted page into descriptors and queue them as expected beats.
  function automatic void cut_page(input dsl_pkg::in_item_t pg);
    int unsigned               len;
    int unsigned               off;
    int unsigned               piece;
    logic [dsl_pkg::CNT_W-1:0] cap;
    bit                        closes;
    dsl_pkg::out_item_t        d;
    cap = eff_capacity();
    if (dropping) begin
      if (pg.last_page) rearm_list();
      return;
    end
    // A fresh transfer starts with a full section.
    if (next_slot == '0) sec_left = eff_section();
    len = 32'(pg.page_bytes);
    if (len > dsl_pkg::PAGE_BYTES) len = 32'(dsl_pkg::PAGE_BYTES);
    off = 0;
    while (len > 0) begin
      d = '0;
      // Out of slots: one error beat, then drop until the last page.
      if (next_slot >= cap) begin
        d.overflow_error = 1'b1;
        d.last           = 1'b1;
        pending_descs.push_back(d);
        dropping = 1'b1;
        if (pg.last_page) rearm_list();
        return;
      end
      if (len >= sec_left) begin
        piece    = 32'(sec_left);
        closes   = 1'b1;
        sec_left = eff_section();
      end else begin
        piece    = len;
        closes   = 1'b0;
        sec_left = sec_left - len[dsl_pkg::SEC_W-1:0];
      end
      len = len - piece;
      d.entry_index = next_slot[dsl_pkg::IDX_W-1:0];
      next_slot     = next_slot + 1'b1;
      d.next_index  = (next_slot >= cap) ? '0 : next_slot[dsl_pkg::IDX_W-1:0];
      d.bus_address    = pg.page_address + 64'(off);
      d.device_address = reg_local;
      d.byte_count     = piece[dsl_pkg::LEN_W-1:0];
      d.direction_in   = reg_to_host;
      d.term_interrupt = closes;
      // The final descriptor closes the ring back to slot 0.
      if (pg.last_page && len == 0) begin
        d.term_interrupt = 1'b1;
        d.next_index     = '0;
        d.end_of_chain   = 1'b1;
      end
      d.last = (len == 0);
      pending_descs.push_back(d);
      off = off + piece;
    end
    if (pg.last_page) rearm_list();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Compare every accepted output beat with the oldest expected descriptor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_descs.size() == 0) begin
        report_mismatch("output beat with no descriptor expected");
      end else begin
        want_desc = pending_descs.pop_front();
        check_field("entry_index", 64'(out_data.entry_index),
                    64'(want_desc.entry_index));
        check_field("bus_address", out_data.bus_address, want_desc.bus_address);
        check_field("device_address", 64'(out_data.device_address),
                    64'(want_desc.device_address));
        check_field("byte_count", 64'(out_data.byte_count),
                    64'(want_desc.byte_count));
        check_field("direction_in", 64'(out_data.direction_in),
                    64'(want_desc.direction_in));
        check_field("term_interrupt", 64'(out_data.term_interrupt),
                    64'(want_desc.term_interrupt));
        check_field("next_index", 64'(out_data.next_index),
                    64'(want_desc.next_index));
        check_field("end_of_chain", 64'(out_data.end_of_chain),
                    64'(want_desc.end_of_chain));
        check_field("overflow_error", 64'(out_data.overflow_error),
                    64'(want_desc.overflow_error));
        check_field("last", 64'(out_data.last), 64'(want_desc.last));
      end
    end
  end

  // Receiver: random stall runs, a long counted hold on request, or none at all.
  initial begin : receiver
    int  hold_count;
    bit  stalling;
    out_stall <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        hold_count = HOLD_CYCLES;
        while (hold_count > 0) begin
          @(posedge clk);
          hold_count--;
        end
      end else if (!idle_en) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        stalling = ($urandom_range(0, 2) == 0);
        out_stall <= stalling;
        repeat (stalling ? 1 + pick_gap() : $urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Register write; the predictor copy follows the masking of the register width.
  task automatic write_reg(input logic [dsl_pkg::REG_IDX_W-1:0] idx,
                           input logic [dsl_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dsl_pkg::REG_SECTION_LENGTH: reg_section  = value[dsl_pkg::SEC_W-1:0];
      dsl_pkg::REG_LOCAL_ADDRESS:  reg_local    = value[dsl_pkg::DEV_W-1:0];
      dsl_pkg::REG_TO_HOST:        reg_to_host  = value[0];
      dsl_pkg::REG_ENTRY_CAPACITY: reg_capacity = value[dsl_pkg::CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one page beat and hold it until the block takes it.
  task automatic send_page(input logic [dsl_pkg::ADDR_W-1:0] addr,
                           input int unsigned nbytes, input bit lastp);
    dsl_pkg::in_item_t pg;
    int                gap;
    pg.page_address = addr;
    pg.page_bytes   = nbytes[dsl_pkg::LEN_W-1:0];
    pg.last_page    = lastp;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cut_page(pg);
  endtask

  // Let every expected beat arrive, then give an empty page time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_descs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [dsl_pkg::ADDR_W-1:0] random_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return {$urandom, $urandom} & ~64'hFFF;
    if (r < 3) return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 4095);
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned random_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 8)  return $urandom_range(4097, 8191);
    if (r < 20) return 4096;
    if (r < 45) return $urandom_range(1, 256);
    return $urandom_range(1, 4096);
  endfunction

  // Reset values must hold before any register is written.
  task automatic test_reset_defaults();
    send_page(64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b0);
    send_page(64'h0, 4095, 1'b0);
    send_page(64'h8000_0000_0000_0000, 8191, 1'b0);
    send_page(64'h0123_4567_89AB_CDEF, 0, 1'b0);
    send_page(64'h0000_0000_0000_1000, 2048, 1'b1);
    // An empty last page still re-arms the list.
    send_page(64'h5555_AAAA_5555_AAAA, 100, 1'b0);
    send_page(64'h0, 0, 1'b1);
    send_page(64'hAAAA_5555_AAAA_5555, 100, 1'b1);
    wait_idle();
  endtask

  // Short sections are raised to the minimum; the widest section never closes.
  task automatic test_section_clamp();
    write_reg(dsl_pkg::REG_SECTION_LENGTH, 32'hFF00_0000);
    write_reg(dsl_pkg::REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
    write_reg(dsl_pkg::REG_TO_HOST, 32'hFFFF_FFFE);
    send_page(64'hFFFF_FFFF_FFFF_FF80, 4096, 1'b1);
    wait_idle();
    write_reg(dsl_pkg::REG_SECTION_LENGTH, 32'd127);
    send_page(random_addr(), 200, 1'b0);
    send_page(random_addr(), 56, 1'b1);
    wait_idle();
    write_reg(dsl_pkg::REG_SECTION_LENGTH, 32'h00FF_FFFF);
    write_reg(dsl_pkg::REG_LOCAL_ADDRESS, 32'h0);
    write_reg(dsl_pkg::REG_TO_HOST, 32'h1);
    send_page(random_addr(), 4096, 1'b0);
    send_page(random_addr(), 4096, 1'b1);
    wait_idle();
  endtask

  // Capacity zero acts as one slot; overflow drops pages until the last one.
  task automatic test_capacity_clamp();
    write_reg(dsl_pkg::REG_SECTION_LENGTH, 32'd128);
    write_reg(dsl_pkg::REG_ENTRY_CAPACITY, 32'hFFFF_F800);
    send_page(random_addr(), 300, 1'b0);
    send_page(random_addr(), 50, 1'b0);
    send_page(random_addr(), 0, 1'b0);
    send_page(random_addr(), 60, 1'b1);
    send_page(random_addr(), 100, 1'b1);
    wait_idle();
    write_reg(dsl_pkg::REG_ENTRY_CAPACITY, 32'd2);
    send_page(random_addr(), 128, 1'b0);
    send_page(random_addr(), 0, 1'b1);
    wait_idle();
  endtask

  // Oversized capacity is held to the ring size: fill all slots, then overflow.
  task automatic test_full_ring();
    write_reg(dsl_pkg::REG_ENTRY_CAPACITY, 32'd2047);
    write_reg(dsl_pkg::REG_LOCAL_ADDRESS, $urandom);
    for (int i = 0; i < 33; i++) send_page(random_addr(), 4096, 1'b0);
    send_page(random_addr(), 1000, 1'b1);
    wait_idle();
  endtask

  // Long receiver hold while pages keep coming, so the block backs up its input.
  task automatic test_output_backpressure();
    write_reg(dsl_pkg::REG_SECTION_LENGTH, 32'd128);
    write_reg(dsl_pkg::REG_ENTRY_CAPACITY, 32'd1024);
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) send_page(random_addr(), 512, i == 23);
    wait_idle();
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_streaming();
    write_reg(dsl_pkg::REG_SECTION_LENGTH, 32'd1000);
    write_reg(dsl_pkg::REG_ENTRY_CAPACITY, 32'd64);
    idle_en = 1'b0;
    for (int i = 0; i < 30; i++) send_page(random_addr(), random_bytes(), (i % 6) == 5);
    wait_idle();
    idle_en = 1'b1;
  endtask

  function automatic logic [dsl_pkg::CFG_W-1:0] random_section();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 127) | ($urandom_range(0, 255) << 24);
    if (r < 40) return $urandom_range(128, 512);
    if (r < 75) return $urandom_range(513, 8192);
    if (r < 90) return $urandom_range(8193, 65535);
    return $urandom;
  endfunction

  function automatic logic [dsl_pkg::CFG_W-1:0] random_capacity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(1, 6);
    if (r < 55) return $urandom_range(7, 64);
    if (r < 75) return $urandom_range(65, 1023);
    if (r < 88) return 32'd1024;
    if (r < 94) return $urandom & 32'hFFFF_F800;
    return $urandom_range(1025, 2047) | ($urandom & 32'hFFFF_F800);
  endfunction

  // Random settings per phase; mostly complete transfers, some left open.
  task automatic test_random_transfers(input int phases, input int pages_per_phase);
    int sent;
    int run_len;
    for (int ph = 0; ph < phases; ph++) begin
      wait_idle();
      write_reg(dsl_pkg::REG_SECTION_LENGTH, random_section());
      write_reg(dsl_pkg::REG_LOCAL_ADDRESS, $urandom);
      write_reg(dsl_pkg::REG_TO_HOST, $urandom);
      write_reg(dsl_pkg::REG_ENTRY_CAPACITY, random_capacity());
      sent = 0;
      while (sent < pages_per_phase) begin
        run_len = $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++) begin
          send_page(random_addr(), random_bytes(),
                    (k == run_len - 1) && ($urandom_range(0, 9) != 0));
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    reg_section  = dsl_pkg::SECTION_RESET;
    reg_local    = dsl_pkg::LOCAL_RESET;
    reg_to_host  = dsl_pkg::TO_HOST_RESET;
    reg_capacity = dsl_pkg::CAPACITY_RESET;
    rearm_list();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_section_clamp();
    test_capacity_clamp();
    test_full_ring();
    test_output_backpressure();
    test_streaming();
    test_random_transfers(6, 48);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_descs.size() != 0)
      report_mismatch($sformatf("%0d descriptors never arrived", pending_descs.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dsl_pkg.sv
design/dsl_piece_alu.sv
design/dsl_ctrl.sv
design/dma_scatter_list_builder.sv
sim/tb_top.sv
